// ----- design/bidirectional_flow_table_top_assert.svh -----
`ifndef BIDIRECTIONAL_FLOW_TABLE_TOP_ASSERT_SVH
`define BIDIRECTIONAL_FLOW_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BFT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bft check failed");

// next-cycle implication, checked outside reset
`define BFT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bft check failed");

`endif

// ----- design/bft_pkg.sv -----
package bft_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);

  localparam logic [31:0] HASH_SEED = 32'd5381;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } bft_state_t;

  typedef struct packed {
    logic              load;
    logic              update;
    logic              clr_wr;
    logic [SLOT_W-1:0] clr_idx;
  } bft_cmd_t;

  typedef struct packed {
    logic proto_ok;
    logic out_free;
  } bft_sts_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    logic [15:0] flow_id;
    logic [31:0] cnt_ab;
    logic [31:0] cnt_ba;
    logic [31:0] cnt_total;
  } bft_entry_t;

endpackage

// ----- design/bft_ctrl.sv -----
module bft_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bft_pkg::bft_sts_t sts,
  output bft_pkg::bft_cmd_t cmd
);
  import bft_pkg::*;

  bft_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] clr_idx_r, clr_idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    in_stall    = 1'b1;
    cmd         = '0;
    cmd.clr_idx = clr_idx_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == SLOT_W'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && sts.proto_ok) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts.out_free) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/bft_dp.sv -----
module bft_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [31:0]               in_src_addr,
  input  logic [31:0]               in_dst_addr,
  input  logic [15:0]               in_src_port_num,
  input  logic [15:0]               in_dst_port_num,
  input  logic [7:0]                in_ip_protocol,
  input  bft_pkg::bft_cmd_t         cmd,
  output bft_pkg::bft_sts_t         sts,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [bft_pkg::SLOT_W-1:0] out_slot_index,
  output logic [15:0]               out_conversation_id,
  output logic                      out_new_flow,
  output logic                      out_reverse_dir,
  output logic [31:0]               out_count_a_to_b,
  output logic [31:0]               out_count_b_to_a,
  output logic [31:0]               out_count_total
);
  import bft_pkg::*;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  bft_entry_t        table_mem [TABLE_DEPTH];
  bft_entry_t        rd_entry_r;
  logic [31:0]       src_r, dst_r;
  logic [7:0]        proto_r;
  logic [SLOT_W-1:0] slot_r;
  logic [15:0]       tcp_id_r, tcp_id_nxt;
  logic [15:0]       udp_id_r, udp_id_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              rev_r, fresh_r;
  bft_entry_t        res_r;

  logic [31:0]       hash_c;
  logic [SLOT_W-1:0] slot_c;
  logic              hit_c, fwd_c;
  bft_entry_t        entry_nxt;
  logic              we_c;
  logic [SLOT_W-1:0] waddr_c;
  bft_entry_t        wdata_c;

  assign hash_c = HASH_SEED ^ in_src_addr ^ in_dst_addr ^ {16'd0, in_src_port_num}
                ^ {16'd0, in_dst_port_num} ^ {24'd0, in_ip_protocol};
  assign slot_c = hash_c[SLOT_W-1:0];

  assign sts.proto_ok = (in_ip_protocol == PROTO_TCP) || (in_ip_protocol == PROTO_UDP);
  assign sts.out_free = !out_valid_r || !out_stall;

  // match in either direction
  assign fwd_c = (rd_entry_r.addr_a == src_r);
  assign hit_c = rd_entry_r.valid &&
                 ((fwd_c && rd_entry_r.addr_b == dst_r) ||
                  (rd_entry_r.addr_a == dst_r && rd_entry_r.addr_b == src_r));

  always_comb begin
    entry_nxt  = rd_entry_r;
    tcp_id_nxt = tcp_id_r;
    udp_id_nxt = udp_id_r;
    if (hit_c) begin
      if (fwd_c) begin
        entry_nxt.cnt_ab = sat_inc(rd_entry_r.cnt_ab);
      end else begin
        entry_nxt.cnt_ba = sat_inc(rd_entry_r.cnt_ba);
      end
      entry_nxt.cnt_total = sat_inc(rd_entry_r.cnt_total);
    end else begin
      entry_nxt.valid     = 1'b1;
      entry_nxt.addr_a    = src_r;
      entry_nxt.addr_b    = dst_r;
      entry_nxt.cnt_ab    = 32'd1;
      entry_nxt.cnt_ba    = 32'd0;
      entry_nxt.cnt_total = 32'd1;
      if (proto_r == PROTO_TCP) begin
        entry_nxt.flow_id = tcp_id_r;
        tcp_id_nxt        = tcp_id_r + 16'd1;
      end else begin
        entry_nxt.flow_id = udp_id_r;
        udp_id_nxt        = udp_id_r + 16'd1;
      end
    end
  end

  // clearing pass and packet update share the write port
  always_comb begin
    we_c    = cmd.clr_wr || cmd.update;
    waddr_c = cmd.clr_wr ? cmd.clr_idx : slot_r;
    wdata_c = cmd.clr_wr ? bft_entry_t'('0) : entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (we_c) begin
      table_mem[waddr_c] <= wdata_c;
    end
    if (cmd.load) begin
      rd_entry_r <= table_mem[slot_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r   <= in_src_addr;
      dst_r   <= in_dst_addr;
      proto_r <= in_ip_protocol;
      slot_r  <= slot_c;
    end
    if (cmd.update) begin
      res_r   <= entry_nxt;
      rev_r   <= hit_c && !fwd_c;
      fresh_r <= !hit_c;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      tcp_id_r    <= '0;
      udp_id_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.update) begin
        tcp_id_r <= tcp_id_nxt;
        udp_id_r <= udp_id_nxt;
      end
    end
  end

  // output beat holds its slot in out_slot_r, loaded from slot_r on each update
  logic [SLOT_W-1:0] out_slot_r;
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_slot_r <= slot_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_slot_index      = out_slot_r;
  assign out_conversation_id = res_r.flow_id;
  assign out_new_flow        = fresh_r;
  assign out_reverse_dir     = rev_r;
  assign out_count_a_to_b    = res_r.cnt_ab;
  assign out_count_b_to_a    = res_r.cnt_ba;
  assign out_count_total     = res_r.cnt_total;

endmodule

// ----- design/bidirectional_flow_table_top.sv -----
// Direct-mapped bidirectional flow table, one packet header per input beat.
// Input channel: in_valid/in_stall carries source and destination address,
// ports and IP protocol. A beat is taken when in_valid is high and in_stall
// is low. Beats that are neither TCP nor UDP are taken and give no result.
// Result channel: out_valid/out_stall carries slot index, conversation id,
// new-flow and reverse-direction flags and the three saturating counts of
// the flow after this packet.
// A TCP or UDP beat taken in idle loads its table read; the lookup state then
// writes the updated entry and the result once the output register is free.
// One table read-modify-write per packet through a single-port-write,
// registered-read memory of 1024 entries: no new packet is taken before
// that write; non-TCP/UDP beats are taken every cycle while idle. Reset: a
// clearing pass sets every slot invalid, one slot per cycle, in_stall high.
// Receiver stall: the result sits in the output register; the block takes the
// next packet but holds its table update until that register is free, so in_stall stays high.
module bidirectional_flow_table_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [31:0]                in_src_addr,
  input  logic [31:0]                in_dst_addr,
  input  logic [15:0]                in_src_port_num,
  input  logic [15:0]                in_dst_port_num,
  input  logic [7:0]                 in_ip_protocol,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bft_pkg::SLOT_W-1:0] out_slot_index,
  output logic [15:0]                out_conversation_id,
  output logic                       out_new_flow,
  output logic                       out_reverse_dir,
  output logic [31:0]                out_count_a_to_b,
  output logic [31:0]                out_count_b_to_a,
  output logic [31:0]                out_count_total
);
  import bft_pkg::*;

  bft_cmd_t cmd;
  bft_sts_t sts;

  bft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bft_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_src_addr         (in_src_addr),
    .in_dst_addr         (in_dst_addr),
    .in_src_port_num     (in_src_port_num),
    .in_dst_port_num     (in_dst_port_num),
    .in_ip_protocol      (in_ip_protocol),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_slot_index      (out_slot_index),
    .out_conversation_id (out_conversation_id),
    .out_new_flow        (out_new_flow),
    .out_reverse_dir     (out_reverse_dir),
    .out_count_a_to_b    (out_count_a_to_b),
    .out_count_b_to_a    (out_count_b_to_a),
    .out_count_total     (out_count_total)
  );

endmodule

// ----- design/bft_checker.sv -----
`include "bidirectional_flow_table_top_assert.svh"

module bft_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [31:0]                in_src_addr,
  input logic [31:0]                in_dst_addr,
  input logic [15:0]                in_src_port_num,
  input logic [15:0]                in_dst_port_num,
  input logic [7:0]                 in_ip_protocol,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [bft_pkg::SLOT_W-1:0] out_slot_index,
  input logic [15:0]                out_conversation_id,
  input logic                       out_new_flow,
  input logic                       out_reverse_dir,
  input logic [31:0]                out_count_a_to_b,
  input logic [31:0]                out_count_b_to_a,
  input logic [31:0]                out_count_total
);
  import bft_pkg::*;

  logic in_take_pkt;
  assign in_take_pkt = in_valid && !in_stall &&
                       (in_ip_protocol == PROTO_TCP || in_ip_protocol == PROTO_UDP);

  // stalled result beat holds
  `BFT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_slot_index) && $stable(out_conversation_id) && $stable(out_count_total))

  // a table lookup is in flight after a packet beat
  `BFT_ASSERT_NXT(a_one_lookup, in_take_pkt, in_stall)

  // a fresh flow starts with one forward packet
  `BFT_ASSERT_IMP(a_new_counts, out_valid && out_new_flow, !out_reverse_dir && out_count_a_to_b == 32'd1 && out_count_b_to_a == 32'd0 && out_count_total == 32'd1)

  // reverse traffic only on an existing flow
  `BFT_ASSERT_IMP(a_rev_hit, out_valid && out_reverse_dir, !out_new_flow && out_count_b_to_a != 32'd0 && out_count_total != 32'd0)

endmodule

bind bidirectional_flow_table_top bft_checker u_bft_checker (.*);
